@@ design/bif_pkg.sv @@
package bif_pkg;

  localparam int unsigned ImgDimW   = 9;
  localparam int unsigned CoordW    = 8;
  localparam int unsigned PixAddrW  = 2 * CoordW;
  localparam int unsigned WeightW   = 17;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned WtW       = 18;   // (17b * 17b) >> 16
  localparam int unsigned WsumW     = 26;   // up to 225 neighbours of WtW
  localparam int unsigned CsumW     = 34;   // WsumW + 8
  localparam int unsigned DivW      = 35;
  localparam int unsigned RadW      = 3;
  localparam int unsigned SpDepth   = 225;
  localparam int unsigned SpIdxW    = 8;

  localparam logic [ImgDimW-1:0] MaxDim = 9'd256;
  localparam logic [15:0] LumaB = 16'd7471;
  localparam logic [15:0] LumaG = 16'd38470;
  localparam logic [15:0] LumaR = 16'd19595;

  localparam logic [1:0] OP_RANGE   = 2'd0;
  localparam logic [1:0] OP_SPATIAL = 2'd1;
  localparam logic [1:0] OP_PIXEL   = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;

  localparam logic [3:0] DivLoad = 4'd8;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic [7:0]         in_blue;
    logic [7:0]         in_green;
    logic [7:0]         in_red;
    logic [7:0]         table_index;
    logic [WeightW-1:0] table_weight;
  } in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       zero_weight;
  } out_t;

  typedef struct packed {
    logic accept;
    logic capture_center;
    logic walk_en;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic in_image;
    logic walk_last;
    logic pipe_empty;
    logic div_done;
  } status_t;

endpackage

@@ design/bif_ctrl.sv @@
module bif_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  bif_pkg::status_t status_i,
  output bif_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CENTER = 6'b000010,
    S_WALK   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = in_valid_i && (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && status_i.is_query) begin
          if (status_i.in_image) begin
            state_d = S_CENTER;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d = S_DIV;
          end
        end
      end
      S_CENTER: begin
        cmd_o.capture_center = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (status_i.walk_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (status_i.pipe_empty) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/bif_dpath.sv @@
module bif_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [8:0]       cfg_data_i,
  input  bif_pkg::in_t     in_data_i,
  output bif_pkg::out_t    out_data_o,
  input  bif_pkg::cmd_t    cmd_i,
  output bif_pkg::status_t status_o
);

  // configuration
  logic [bif_pkg::ImgDimW-1:0] width_q, height_q, w_sat, h_sat;
  logic [bif_pkg::RadW-1:0]    radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bif_pkg::MaxDim;
      height_q <= bif_pkg::MaxDim;
      radius_q <= bif_pkg::RadW'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bif_pkg::CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i;
        bif_pkg::CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i;
        bif_pkg::CFG_WINDOW_RADIUS: radius_q <= cfg_data_i[bif_pkg::RadW-1:0];
        default: ;
      endcase
    end
  end

  assign w_sat = (width_q  > bif_pkg::MaxDim) ? bif_pkg::MaxDim : width_q;
  assign h_sat = (height_q > bif_pkg::MaxDim) ? bif_pkg::MaxDim : height_q;

  logic acc_query;
  assign acc_query = cmd_i.accept && (in_data_i.operation == bif_pkg::OP_QUERY);

  assign status_o.is_query = (in_data_i.operation == bif_pkg::OP_QUERY);
  assign status_o.in_image = ({1'b0, in_data_i.pos_x} < w_sat) &&
                             ({1'b0, in_data_i.pos_y} < h_sat);

  // query context
  logic [7:0]                  qx_q, qy_q, cl_q;
  logic [bif_pkg::ImgDimW-1:0] qw_q, qh_q;
  logic [bif_pkg::RadW-1:0]    rad_q;

  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      qx_q  <= in_data_i.pos_x;
      qy_q  <= in_data_i.pos_y;
      qw_q  <= w_sat;
      qh_q  <= h_sat;
      rad_q <= radius_q;
    end
  end

  // window walk
  logic signed [4:0] dx_q, dy_q, rad_s;
  logic [bif_pkg::SpIdxW-1:0] sidx_q;
  logic signed [9:0] nx, ny;
  logic nb_ok, walk_last;

  assign rad_s     = $signed({2'b00, rad_q});
  assign walk_last = (dx_q == rad_s) && (dy_q == rad_s);
  assign status_o.walk_last = walk_last;
  assign nx = $signed({2'b00, qx_q}) + 10'(dx_q);
  assign ny = $signed({2'b00, qy_q}) + 10'(dy_q);
  assign nb_ok = !nx[9] && (nx[8:0] < qw_q) && !ny[9] && (ny[8:0] < qh_q);

  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      dx_q   <= 5'sd0 - $signed({2'b00, radius_q});
      dy_q   <= 5'sd0 - $signed({2'b00, radius_q});
      sidx_q <= '0;
    end else if (cmd_i.walk_en) begin
      sidx_q <= sidx_q + bif_pkg::SpIdxW'(1);
      if (dx_q == rad_s) begin
        dx_q <= -rad_s;
        dy_q <= dy_q + 5'sd1;
      end else begin
        dx_q <= dx_q + 5'sd1;
      end
    end
  end

  // pixel store: {luma, red, green, blue}
  logic [31:0] pix_mem [2**bif_pkg::PixAddrW];
  logic [31:0] pix_rdata_q;
  logic [bif_pkg::PixAddrW-1:0] pix_raddr;
  logic [24:0] luma_sum;
  logic pix_we;

  assign luma_sum = 25'(bif_pkg::LumaB) * 25'(in_data_i.in_blue)
                  + 25'(bif_pkg::LumaG) * 25'(in_data_i.in_green)
                  + 25'(bif_pkg::LumaR) * 25'(in_data_i.in_red);
  assign pix_we    = cmd_i.accept && (in_data_i.operation == bif_pkg::OP_PIXEL);
  assign pix_raddr = cmd_i.accept ? {in_data_i.pos_y, in_data_i.pos_x}
                                  : {ny[7:0], nx[7:0]};

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[{in_data_i.pos_y, in_data_i.pos_x}] <=
        {luma_sum[23:16], in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
    end
    pix_rdata_q <= pix_mem[pix_raddr];
  end

  // weight tables
  logic [bif_pkg::WeightW-1:0] sp_mem [bif_pkg::SpDepth];
  logic [bif_pkg::WeightW-1:0] rng_mem [256];
  logic [bif_pkg::WeightW-1:0] sp_rdata_q, rng_rdata_q;
  logic [7:0] diff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_data_i.operation == bif_pkg::OP_SPATIAL) &&
        (32'(in_data_i.table_index) < bif_pkg::SpDepth)) begin
      sp_mem[in_data_i.table_index] <= in_data_i.table_weight;
    end
    sp_rdata_q <= sp_mem[sidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_data_i.operation == bif_pkg::OP_RANGE)) begin
      rng_mem[in_data_i.table_index] <= in_data_i.table_weight;
    end
    rng_rdata_q <= rng_mem[diff];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_center) cl_q <= pix_rdata_q[31:24];
  end

  assign diff = (pix_rdata_q[31:24] > cl_q) ? pix_rdata_q[31:24] - cl_q
                                            : cl_q - pix_rdata_q[31:24];

  // neighbour pipeline: read -> range lookup -> weight -> accumulate
  logic v1_q, v2_q, v3_q;
  logic [23:0] bgr2_q, bgr3_q;
  logic [bif_pkg::WeightW-1:0] sp2_q;
  logic [2*bif_pkg::WeightW-1:0] wprod;
  logic [bif_pkg::WtW-1:0] wt3_q;
  logic [bif_pkg::CsumW-1:0] sb_q, sg_q, sr_q;
  logic [bif_pkg::WsumW-1:0] ws_q;

  assign wprod = 34'(sp2_q) * 34'(rng_rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.walk_en && nb_ok;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign status_o.pipe_empty = !v1_q && !v2_q && !v3_q;

  always_ff @(posedge clk_i) begin
    bgr2_q <= pix_rdata_q[23:0];
    sp2_q  <= sp_rdata_q;
    bgr3_q <= bgr2_q;
    wt3_q  <= wprod[bif_pkg::FracBits +: bif_pkg::WtW];
    if (acc_query) begin
      sb_q <= '0;
      sg_q <= '0;
      sr_q <= '0;
      ws_q <= '0;
    end else if (v3_q) begin
      sb_q <= sb_q + bif_pkg::CsumW'(26'(wt3_q) * 26'(bgr3_q[7:0]));
      sg_q <= sg_q + bif_pkg::CsumW'(26'(wt3_q) * 26'(bgr3_q[15:8]));
      sr_q <= sr_q + bif_pkg::CsumW'(26'(wt3_q) * 26'(bgr3_q[23:16]));
      ws_q <= ws_q + bif_pkg::WsumW'(wt3_q);
    end
  end

  // shared divider: one quotient bit per cycle, three channels in turn
  logic       div_busy_q;
  logic [1:0] div_ch_q;
  logic [3:0] div_step_q;
  logic [bif_pkg::DivW-1:0] n_q, n_load, shifted;
  logic       ovf_q, ge;
  logic [7:0] qacc_q, qnext, qfinal;
  logic [bif_pkg::CsumW-1:0] sel_sum;
  logic [7:0] res_b_q, res_g_q, res_r_q;

  always_comb begin
    case (div_ch_q)
      2'd0:    sel_sum = sb_q;
      2'd1:    sel_sum = sg_q;
      2'd2:    sel_sum = sr_q;
      default: sel_sum = '0;
    endcase
  end

  assign n_load  = bif_pkg::DivW'(sel_sum) + bif_pkg::DivW'(ws_q >> 1);
  assign shifted = bif_pkg::DivW'(ws_q) << div_step_q[2:0];
  assign ge      = (n_q >= shifted);
  assign qnext   = qacc_q | (8'(ge) << div_step_q[2:0]);
  assign qfinal  = ovf_q ? 8'd255 : qnext;
  assign status_o.div_done = div_busy_q && (div_step_q == 4'd0) && (div_ch_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_ch_q   <= '0;
      div_step_q <= bif_pkg::DivLoad;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_ch_q   <= '0;
      div_step_q <= bif_pkg::DivLoad;
    end else if (div_busy_q) begin
      if (div_step_q == bif_pkg::DivLoad) begin
        div_step_q <= 4'd7;
      end else if (div_step_q == 4'd0) begin
        div_step_q <= bif_pkg::DivLoad;
        if (div_ch_q == 2'd2) div_busy_q <= 1'b0;
        else div_ch_q <= div_ch_q + 2'd1;
      end else begin
        div_step_q <= div_step_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_busy_q) begin
      if (div_step_q == bif_pkg::DivLoad) begin
        n_q    <= n_load;
        ovf_q  <= (n_load >= bif_pkg::DivW'({ws_q, 8'b0}));
        qacc_q <= '0;
      end else begin
        if (ge) n_q <= n_q - shifted;
        qacc_q <= qnext;
        if (div_step_q == 4'd0) begin
          case (div_ch_q)
            2'd0:    res_b_q <= qfinal;
            2'd1:    res_g_q <= qfinal;
            default: res_r_q <= qfinal;
          endcase
        end
      end
    end
  end

  // result register
  bif_pkg::out_t out_q;
  logic zero_ws;
  assign zero_ws = (ws_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_blue    <= zero_ws ? 8'd0 : res_b_q;
      out_q.out_green   <= zero_ws ? 8'd0 : res_g_q;
      out_q.out_red     <= zero_ws ? 8'd0 : res_r_q;
      out_q.zero_weight <= zero_ws;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ design/bilateral_image_filter.sv @@
// Table loads and pixel writes give no result and do not stall the input.
// A filter query inside the image does one pixel memory read per window
// neighbour, a four-deep weight pipeline, then a shared divider producing one
// quotient bit per cycle after a load step for each of the three channels.
// One query is processed at a time; a finished result waits in an output register.
// Reset sets width/height to 256 and radius to 2; the memories are not cleared.
module bilateral_image_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [8:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bif_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bif_pkg::out_t out_data_o
);

  bif_pkg::cmd_t    cmd;
  bif_pkg::status_t status;

  bif_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bif_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ tb/bilateral_image_filter_checker.sv @@
`timescale 1ns / 1ps

module bilateral_image_filter_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [8:0]    cfg_data_i,
  input  logic          in_valid_i,
  input  logic          in_stall_o,
  input  bif_pkg::in_t  in_data_i,
  input  logic          out_valid_o,
  input  logic          out_stall_i,
  input  bif_pkg::out_t out_data_o,
  output int            fail_count_o,
  output int            pending_o,
  output int            queries_o,
  output int            zero_flags_o
);

  logic [31:0]                 pixel_mem [65536];
  logic [bif_pkg::WeightW-1:0] range_wt [256];
  logic [bif_pkg::WeightW-1:0] spatial_wt [bif_pkg::SpDepth];
  logic [8:0]                  img_w, img_h;
  logic [2:0]                  radius;
  bif_pkg::out_t               expected_q [$];

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic logic [7:0] round_div(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    q = (num + den / 2) / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic bif_pkg::out_t filter_pixel(input logic [7:0] cx,
                                                 input logic [7:0] cy);
    int w, h, r, nx, ny;
    logic [7:0] c_luma, n_luma, diff;
    logic [31:0] p;
    longint unsigned wt, sb, sg, sr, ws;
    bif_pkg::out_t res;
    w = (img_w > 256) ? 256 : img_w;
    h = (img_h > 256) ? 256 : img_h;
    r = radius;
    sb = 0; sg = 0; sr = 0; ws = 0;
    if (cx < w && cy < h) begin
      c_luma = pixel_mem[{cy, cx}][31:24];
      for (int dy = -r; dy <= r; dy++) begin
        for (int dx = -r; dx <= r; dx++) begin
          nx = cx + dx;
          ny = cy + dy;
          if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
          p = pixel_mem[ny * 256 + nx];
          n_luma = p[31:24];
          diff = (n_luma > c_luma) ? n_luma - c_luma : c_luma - n_luma;
          wt = (64'(spatial_wt[(dy + r) * (2 * r + 1) + dx + r]) *
                64'(range_wt[diff])) >> bif_pkg::FracBits;
          sb += wt * p[7:0];
          sg += wt * p[15:8];
          sr += wt * p[23:16];
          ws += wt;
        end
      end
    end
    if (ws == 0) begin
      res = '{out_blue: 8'd0, out_green: 8'd0, out_red: 8'd0, zero_weight: 1'b1};
    end else begin
      res.out_blue    = round_div(sb, ws);
      res.out_green   = round_div(sg, ws);
      res.out_red     = round_div(sr, ws);
      res.zero_weight = 1'b0;
    end
    return res;
  endfunction

  assign pending_o = expected_q.size();

  initial begin
    fail_count_o = 0;
    queries_o = 0;
    zero_flags_o = 0;
    img_w = 9'd256;
    img_h = 9'd256;
    radius = 3'd2;
  end

  always @(posedge clk_i) begin
    bif_pkg::in_t it;
    bif_pkg::out_t exp_res;
    logic [31:0] luma;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bif_pkg::CFG_IMAGE_WIDTH:   img_w = cfg_data_i;
          bif_pkg::CFG_IMAGE_HEIGHT:  img_h = cfg_data_i;
          bif_pkg::CFG_WINDOW_RADIUS: radius = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        it = in_data_i;
        case (it.operation)
          bif_pkg::OP_RANGE: range_wt[it.table_index] = it.table_weight;
          bif_pkg::OP_SPATIAL: begin
            if (it.table_index < bif_pkg::SpDepth)
              spatial_wt[it.table_index] = it.table_weight;
          end
          bif_pkg::OP_PIXEL: begin
            luma = (32'd7471 * it.in_blue + 32'd38470 * it.in_green +
                    32'd19595 * it.in_red) >> 16;
            pixel_mem[{it.pos_y, it.pos_x}] = {luma[7:0], it.in_red, it.in_green,
                                               it.in_blue};
          end
          default: begin
            exp_res = filter_pixel(it.pos_x, it.pos_y);
            expected_q.push_back(exp_res);
            queries_o++;
            if (exp_res.zero_weight) zero_flags_o++;
          end
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("result transaction with nothing expected", 1, 0);
        end else begin
          exp_res = expected_q.pop_front();
          if (out_data_o.out_blue !== exp_res.out_blue)
            report("out_blue", out_data_o.out_blue, exp_res.out_blue);
          if (out_data_o.out_green !== exp_res.out_green)
            report("out_green", out_data_o.out_green, exp_res.out_green);
          if (out_data_o.out_red !== exp_res.out_red)
            report("out_red", out_data_o.out_red, exp_res.out_red);
          if (out_data_o.zero_weight !== exp_res.zero_weight)
            report("zero_weight", out_data_o.zero_weight, exp_res.zero_weight);
        end
      end
    end
  end

endmodule

@@ tb/bilateral_image_filter_tb.sv @@
`timescale 1ns / 1ps

module bilateral_image_filter_tb;

  localparam int StallLimit = 6000;
  localparam int HoldOff = 400;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [8:0] cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  bif_pkg::in_t  in_data_i;
  bif_pkg::out_t out_data_o;
  int   fail_count, pending, queries, zero_flags;

  int   items_sent;
  bit   hold_req;
  bit   no_gaps;
  bit   pixel_written [65536];
  int   cur_w, cur_h, cur_r;

  bilateral_image_filter i_dut (.*);

  bilateral_image_filter_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o,
    .fail_count_o(fail_count), .pending_o(pending), .queries_o(queries),
    .zero_flags_o(zero_flags)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bif_pkg::in_t rand_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(bif_pkg::in_t)-1:0];
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input bif_pkg::in_t it);
    int gap;
    in_valid_i = 1'b1;
    in_data_i = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      in_data_i = rand_item();
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic load_weight(input logic [1:0] op, input int idx, input int wt);
    bif_pkg::in_t it;
    it = rand_item();
    it.operation = op;
    it.table_index = 8'(idx);
    it.table_weight = bif_pkg::WeightW'(wt);
    send_item(it);
  endtask

  task automatic write_pixel(input int x, input int y, input int b, input int g,
                             input int r);
    bif_pkg::in_t it;
    it = rand_item();
    it.operation = bif_pkg::OP_PIXEL;
    it.pos_x = 8'(x);
    it.pos_y = 8'(y);
    it.in_blue = 8'(b);
    it.in_green = 8'(g);
    it.in_red = 8'(r);
    send_item(it);
    pixel_written[y * 256 + x] = 1'b1;
  endtask

  // fills every unwritten in-image neighbour, then queries
  task automatic query_at(input int x, input int y);
    int w, h, nx, ny;
    bif_pkg::in_t it;
    w = (cur_w > 256) ? 256 : cur_w;
    h = (cur_h > 256) ? 256 : cur_h;
    if (x < w && y < h) begin
      for (int dy = -cur_r; dy <= cur_r; dy++) begin
        for (int dx = -cur_r; dx <= cur_r; dx++) begin
          nx = x + dx;
          ny = y + dy;
          if (nx >= 0 && nx < w && ny >= 0 && ny < h && !pixel_written[ny * 256 + nx])
            write_pixel(nx, ny, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
        end
      end
    end
    it = rand_item();
    it.operation = bif_pkg::OP_QUERY;
    it.pos_x = 8'(x);
    it.pos_y = 8'(y);
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input int val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = 9'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input int w, input int h, input int r);
    wait_idle();
    set_reg(bif_pkg::CFG_IMAGE_WIDTH, w);
    set_reg(bif_pkg::CFG_IMAGE_HEIGHT, h);
    set_reg(bif_pkg::CFG_WINDOW_RADIUS, r);
    cur_w = w;
    cur_h = h;
    cur_r = r;
  endtask

  function automatic int rand_weight();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 65536;
    if (roll == 2) return $urandom_range(0, 131071);
    return $urandom_range(1, 65536);
  endfunction

  task automatic random_items(input int count);
    int roll, w, h;
    w = (cur_w > 256) ? 256 : cur_w;
    h = (cur_h > 256) ? 256 : cur_h;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        load_weight(bif_pkg::OP_RANGE, $urandom_range(0, 255), rand_weight());
      end else if (roll < 22) begin
        load_weight(bif_pkg::OP_SPATIAL, $urandom_range(0, 255), rand_weight());
      end else if (roll < 50) begin
        if ($urandom_range(0, 3) == 0 || w == 0 || h == 0)
          write_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        else
          write_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
      end else begin
        if ($urandom_range(0, 7) == 0 || w == 0 || h == 0)
          query_at($urandom_range(0, 255), $urandom_range(0, 255));
        else
          query_at($urandom_range(0, w - 1), $urandom_range(0, h - 1));
      end
      if (n == count / 2 && $urandom_range(0, 2) == 0) hold_req = 1'b1;
    end
    no_gaps = 1'b0;
  endtask

  // receiver side
  initial begin
    int roll;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldOff) @(negedge clk_i);
        hold_req = 1'b0;
      end
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 65) begin
        out_stall_i = 1'b0;
      end else if (roll < 93) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(10, 60)) @(negedge clk_i);
      end
    end
  end

  // watchdog: cycles without any transaction
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle = 0;
      else
        idle++;
      if (idle >= StallLimit) begin
        $display("bilateral_image_filter test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = bif_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    hold_req = 1'b0;
    no_gaps = 1'b0;
    items_sent = 0;
    cur_w = 256;
    cur_h = 256;
    cur_r = 2;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 256; i++)
      load_weight(bif_pkg::OP_RANGE, i, $urandom_range(1, 65536));
    for (int i = 0; i < bif_pkg::SpDepth; i++)
      load_weight(bif_pkg::OP_SPATIAL, i, $urandom_range(1, 65536));

    // directed: extremes, ignored spatial index, weights above one
    configure(256, 256, 2);
    write_pixel(0, 0, 0, 0, 0);
    write_pixel(255, 255, 255, 255, 255);
    write_pixel(0, 255, 255, 0, 255);
    write_pixel(255, 0, 0, 255, 0);
    load_weight(bif_pkg::OP_RANGE, 255, 131071);
    load_weight(bif_pkg::OP_RANGE, 0, 0);
    load_weight(bif_pkg::OP_SPATIAL, 255, 77);
    load_weight(bif_pkg::OP_SPATIAL, 224, 65536);
    load_weight(bif_pkg::OP_SPATIAL, 12, 131071);
    query_at(0, 0);
    query_at(255, 255);
    query_at(255, 0);
    load_weight(bif_pkg::OP_RANGE, 0, 65536);
    query_at(128, 77);

    // zero weight sum with a single-pixel window
    configure(256, 256, 0);
    load_weight(bif_pkg::OP_SPATIAL, 0, 0);
    query_at(10, 20);
    load_weight(bif_pkg::OP_SPATIAL, 0, 40000);
    query_at(10, 20);

    // empty image and query outside
    configure(0, 4, 3);
    query_at(0, 0);
    configure(5, 3, 1);
    query_at(5, 0);
    query_at(0, 3);
    query_at(4, 2);

    // sender waits for the pipeline to drain while the receiver holds off
    hold_req = 1'b1;
    query_at(1, 1);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);

    configure(1, 1, 0);     random_items(12);
    configure(20, 1, 7);    random_items(18);
    configure(1, 20, 7);    random_items(18);
    configure(511, 300, 1); random_items(10);
    configure(8, 8, 3);     hold_req = 1'b1; random_items(30);
    configure(7, 9, 5);     random_items(18);
    configure(0, 0, 4);     random_items(8);
    configure(12, 5, 2);    random_items(18);

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);

    $display("Sent %0d input transactions over 12 register settings", items_sent);
    $display("Checked %0d filter results, %0d with zero weight sum", queries, zero_flags);
    if (fail_count == 0) begin
      $display("bilateral_image_filter test passed");
    end else begin
      $display("bilateral_image_filter test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bif_pkg.sv
design/bif_ctrl.sv
design/bif_dpath.sv
design/bilateral_image_filter.sv
tb/bilateral_image_filter_checker.sv
tb/bilateral_image_filter_tb.sv
